// ===== rtl/arph_pkg.sv =====
// Package for the attitude block: constants, arctangent table and the types
// that pass between the front end, the queue and the CORDIC back end.
// Depends on nothing.
package arph_pkg;

   localparam int TAB_LEN = 24;
   localparam int ZW      = 30;          // Q20 degree accumulator width
   localparam int DW      = 36;          // CORDIC x/y datapath width
   localparam int SQW     = 48;          // (ay^2+az^2) << 16
   localparam int RW      = 24;          // Q8 square root
   localparam logic signed [ZW-1:0] DEG180_Q20 = ZW'(188743680);
   localparam logic signed [17:0] DEG180_Q6 = 18'sd11520;
   localparam logic signed [17:0] DEG90_Q6  = 18'sd5760;
   localparam logic signed [17:0] DEG360_Q6 = 18'sd23040;

   // atan(2^-i) in degrees, Q20
   function automatic logic signed [ZW-1:0] atan_tab(input int i);
      logic signed [ZW-1:0] v;
      begin
         unique case (i)
            0: v = ZW'(47185920);   1: v = ZW'(27855475);
            2: v = ZW'(14718068);   3: v = ZW'(7471121);
            4: v = ZW'(3750058);    5: v = ZW'(1876857);
            6: v = ZW'(938658);     7: v = ZW'(469357);
            8: v = ZW'(234682);     9: v = ZW'(117342);
            10: v = ZW'(58671);     11: v = ZW'(29335);
            12: v = ZW'(14668);     13: v = ZW'(7334);
            14: v = ZW'(3667);      15: v = ZW'(1833);
            16: v = ZW'(917);       17: v = ZW'(458);
            18: v = ZW'(229);       19: v = ZW'(115);
            20: v = ZW'(57);        21: v = ZW'(29);
            22: v = ZW'(14);        23: v = ZW'(7);
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   // one vectoring CORDIC lane
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;         // both operands zero: angle is 0
   } lane_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      lane_type             roll;
      lane_type             pitch;
      lane_type             head;
      logic                 head_fixed;   // mag_y zero: heading known
      logic signed [17:0]   head_q6;
   } work_type;

endpackage

// ===== rtl/arph_front.sv =====
// Front end: squares, pipelined floor square root, and quadrant setup of
// the three atan2 lanes. Uses arph_pkg.
module arph_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [15:0]    accel_x,
   input  logic signed [15:0]    accel_y,
   input  logic signed [15:0]    accel_z,
   input  logic signed [15:0]    mag_x,
   input  logic signed [15:0]    mag_y,
   output logic                  out_valid,
   output arph_pkg::work_type    out_work
);
   import arph_pkg::*;

   localparam int SQ_STEPS = RW;       // one result bit per stage

   typedef struct packed {
      logic signed [15:0] ax, ay, az, mx, my;
   } raw_type;

   // stage 0: register samples and the sum of squares
   logic               s0_valid_ff;
   raw_type            s0_raw_ff;
   logic [SQW-1:0]     s0_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= in_valid;
      end
      s0_raw_ff <= '{accel_x, accel_y, accel_z, mag_x, mag_y};
      s0_sq_ff  <= {SQW'(32'(accel_y * accel_y) + 33'(0)) +
                    SQW'(32'(accel_z * accel_z))} << 16;
   end

   // restoring square root, one bit per stage, MSB first;
   // entry k holds what stage k produced
   logic            sq_valid_ff [SQ_STEPS];
   raw_type         sq_raw_ff   [SQ_STEPS];
   logic [SQW-1:0]  sq_rem_ff   [SQ_STEPS];
   logic [RW-1:0]   sq_res_ff   [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int B = SQ_STEPS - 1 - k;
      logic           valid_src;
      raw_type        raw_src;
      logic [SQW-1:0] rem_src;
      logic [RW-1:0]  res_src;
      logic [SQW+1:0] trial;
      logic [RW-1:0]  res_in;

      // stage input: the sum of squares, or the previous stage
      if (k == 0) begin : g_first
         always_comb begin
            valid_src = s0_valid_ff;
            raw_src   = s0_raw_ff;
            rem_src   = s0_sq_ff;
            res_src   = '0;
         end
      end else begin : g_next
         always_comb begin
            valid_src = sq_valid_ff[k-1];
            raw_src   = sq_raw_ff[k-1];
            rem_src   = sq_rem_ff[k-1];
            res_src   = sq_res_ff[k-1];
         end
      end

      // keep the trial bit if its square still fits
      always_comb begin
         res_in = res_src | (RW'(1) << B);
         trial  = (SQW+2)'(res_in) * (SQW+2)'(res_in);
         if (trial > (SQW+2)'(rem_src)) begin
            res_in = res_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else begin
            sq_valid_ff[k] <= valid_src;
         end
         sq_raw_ff[k] <= raw_src;
         sq_rem_ff[k] <= rem_src;
         sq_res_ff[k] <= res_in;
      end
   end

   // quadrant setup for one lane
   function automatic lane_type setup(input logic signed [DW-1:0] y,
                                      input logic signed [DW-1:0] x);
      lane_type l;
      begin
         l.x    = x;
         l.y    = y;
         l.z    = '0;
         l.zero = (x == 0) && (y == 0);
         if (x < 0) begin
            l.z = (y >= 0) ? DEG180_Q20 : -DEG180_Q20;
            l.x = -x;
            l.y = -y;
         end
         return l;
      end
   endfunction

   raw_type        r;
   logic           fin_valid_ff;
   work_type       fin_work_ff;
   work_type       work_in;

   always_comb begin
      r = sq_raw_ff[SQ_STEPS-1];
      work_in.roll  = setup(DW'(r.ay) <<< 8, DW'(r.az) <<< 8);
      work_in.pitch = setup(-(DW'(r.ax) <<< 8),
                            DW'({1'b0, sq_res_ff[SQ_STEPS-1]}));
      work_in.head  = setup(DW'(r.mx) <<< 8, DW'(r.my) <<< 8);
      work_in.head_fixed = (r.my == '0);
      work_in.head_q6    = (r.mx < 0) ? DEG180_Q6 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= sq_valid_ff[SQ_STEPS-1];
      end
      fin_work_ff <= work_in;
   end

   assign out_valid = fin_valid_ff;
   assign out_work  = fin_work_ff;

endmodule

// ===== rtl/arph_queue.sv =====
// One-entry staging register between front end and CORDIC back end.
// Uses arph_pkg.
module arph_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  arph_pkg::work_type in_work,
   output logic               out_valid,
   output arph_pkg::work_type out_work
);
   import arph_pkg::*;

   // both sides run every cycle, so the queue is a plain staging register
   logic     valid_ff;
   work_type work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      work_ff <= in_work;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== rtl/arph_back.sv =====
// Back end: pipelined vectoring CORDIC for three lanes, rounding, clamping
// and heading declination wrap. Uses arph_pkg.
module arph_back #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  arph_pkg::work_type in_work,
   input  logic signed [14:0] declination,
   output logic               out_valid,
   output logic signed [14:0] roll_angle,
   output logic signed [13:0] pitch_angle,
   output logic signed [14:0] heading_angle
);
   import arph_pkg::*;

   localparam int N = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

   function automatic lane_type rot(input lane_type l, input int i);
      lane_type o;
      begin
         o.zero = l.zero;
         if (l.y >= 0) begin
            o.x = l.x + (l.y >>> i);
            o.y = l.y - (l.x >>> i);
            o.z = l.z + atan_tab(i);
         end else begin
            o.x = l.x - (l.y >>> i);
            o.y = l.y + (l.x >>> i);
            o.z = l.z - atan_tab(i);
         end
         return o;
      end
   endfunction

   // entry i holds what CORDIC stage i produced
   logic     v_ff [N];
   work_type w_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic     v_src;
      work_type w_src;
      work_type w_in;

      // stage input: the queue, or the previous stage
      if (i == 0) begin : g_first
         always_comb begin
            v_src = in_valid;
            w_src = in_work;
         end
      end else begin : g_next
         always_comb begin
            v_src = v_ff[i-1];
            w_src = w_ff[i-1];
         end
      end

      always_comb begin
         w_in = w_src;
         w_in.roll  = rot(w_src.roll, i);
         w_in.pitch = rot(w_src.pitch, i);
         w_in.head  = rot(w_src.head, i);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_src;
         end
         w_ff[i] <= w_in;
      end
   end

   // Q20 to Q6, rounding half up, then clamp to +/-lim
   function automatic logic signed [17:0] q6(input logic signed [ZW-1:0] z,
                                             input logic signed [17:0] lim);
      logic signed [ZW:0]   t;
      logic signed [17:0]   v;
      begin
         t = ((ZW+1)'(z) + (ZW+1)'(8192)) >>> 14;
         v = 18'(t);
         if (v > lim) v = lim;
         else if (v < -lim) v = -lim;
         return v;
      end
   endfunction

   // stage A: round and clamp; both operands zero give angle 0
   logic               a_valid_ff;
   logic signed [17:0] a_roll_ff, a_pitch_ff, a_head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= v_ff[N-1];
      end
      a_roll_ff  <= w_ff[N-1].roll.zero ? 18'sd0
                                        : q6(w_ff[N-1].roll.z, DEG180_Q6);
      a_pitch_ff <= w_ff[N-1].pitch.zero ? 18'sd0
                                         : q6(w_ff[N-1].pitch.z, DEG90_Q6);
      a_head_ff  <= w_ff[N-1].head_fixed ? w_ff[N-1].head_q6
                                         : q6(w_ff[N-1].head.z, DEG180_Q6);
   end

   // stage B: declination and wrap
   logic               b_valid_ff;
   logic signed [14:0] b_roll_ff, b_head_ff;
   logic signed [13:0] b_pitch_ff;
   logic signed [17:0] h;

   always_comb begin
      h = a_head_ff - 18'(declination);
      if (h > DEG180_Q6) h = h - DEG360_Q6;
      else if (h < -DEG180_Q6) h = h + DEG360_Q6;
      if (h > DEG180_Q6) h = DEG180_Q6;
      else if (h < -DEG180_Q6) h = -DEG180_Q6;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_roll_ff  <= 15'(a_roll_ff);
      b_pitch_ff <= 14'(a_pitch_ff);
      b_head_ff  <= 15'(h);
   end

   assign out_valid     = b_valid_ff;
   assign roll_angle    = b_roll_ff;
   assign pitch_angle   = b_pitch_ff;
   assign heading_angle = b_head_ff;

endmodule

// ===== rtl/attitude_roll_pitch_heading.sv =====
// Top level of the attitude block: roll, pitch and heading from one sample.
// Uses arph_pkg, arph_front, arph_queue and arph_back.
//
// One sample is taken every clock (busy is always low) and its result
// appears on the rsp_ ports, marked by rsp_valid for one cycle. rsp_valid
// rises once the sample has passed one input register, 24 square-root
// stages, one setup register, one queue register, N CORDIC stages and two
// output stages, where N is CORDIC_STAGES capped at 24.
// The receiver cannot stall the block.
module attitude_roll_pitch_heading #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic               csr_write,
   input  logic signed [14:0] csr_wdata,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_roll_angle,
   output logic signed [13:0] rsp_pitch_angle,
   output logic signed [14:0] rsp_heading_angle
);
   import arph_pkg::*;

   logic signed [14:0] declination_ff;
   logic               f_valid, q_valid;
   work_type           f_work, q_work;

   // declination register
   always_ff @(posedge clock) begin
      if (reset) begin
         declination_ff <= '0;
      end else if (csr_write) begin
         declination_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   arph_front u_front (
      .clock, .reset, .in_valid(start),
      .accel_x(req_accel_x), .accel_y(req_accel_y), .accel_z(req_accel_z),
      .mag_x(req_mag_x), .mag_y(req_mag_y),
      .out_valid(f_valid), .out_work(f_work)
   );

   arph_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_work(f_work),
      .out_valid(q_valid), .out_work(q_work)
   );

   arph_back #(.STAGES(CORDIC_STAGES)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_work(q_work),
      .declination(declination_ff),
      .out_valid(rsp_valid), .roll_angle(rsp_roll_angle),
      .pitch_angle(rsp_pitch_angle), .heading_angle(rsp_heading_angle)
   );

   // pitch and heading stay in range whenever an item leaves; the queue never makes an item from nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 14'sd5760 && rsp_pitch_angle >= -14'sd5760))
      else $error("pitch out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_angle <= 15'sd11520 && rsp_heading_angle >= -15'sd11520))
      else $error("heading out of range");
   assert property (@(posedge clock) disable iff (reset)
      q_valid |-> $past(f_valid))
      else $error("queue produced an item from nothing");

endmodule

// ===== tb/tb_attitude_roll_pitch_heading.sv =====
// Testbench for attitude_roll_pitch_heading: drives sensor samples, predicts
// roll, pitch and heading with a local CORDIC model and checks every result.
// Depends on the attitude RTL and arph_pkg.
module tb_attitude_roll_pitch_heading;
   import arph_pkg::*;

   localparam int STAGES    = 16;
   localparam int LATENCY   = STAGES + 30;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [13:0] pitch;
      logic signed [14:0] heading;
   } attitude_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [15:0] req_mag_x = '0, req_mag_y = '0;
   logic               csr_write = 1'b0;
   logic signed [14:0] csr_wdata = '0;
   logic               rsp_valid;
   logic signed [14:0] rsp_roll_angle;
   logic signed [13:0] rsp_pitch_angle;
   logic signed [14:0] rsp_heading_angle;

   attitude_type       pending_attitudes[$];
   logic signed [14:0] decl_model = '0;
   int                 fail_count = 0;
   int                 cycle_count = 0;

   attitude_roll_pitch_heading #(.CORDIC_STAGES(STAGES)) dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("attitude_roll_pitch_heading regression: fail");
         $finish;
      end
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // vectoring CORDIC, result in Q20 degrees
   function automatic longint atan2_q20(longint y, longint x);
      longint z, nx, ny;
      int     n;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd188743680 : -64'sd188743680;
         x = -x;
         y = -y;
      end
      n = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;
      for (int i = 0; i < n; i++) begin
         if (y >= 0) begin
            nx = x + shr_floor(y, i);
            ny = y - shr_floor(x, i);
            z += longint'(atan_tab(i));
         end else begin
            nx = x - shr_floor(y, i);
            ny = y + shr_floor(x, i);
            z -= longint'(atan_tab(i));
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic longint q20_to_q6_clamped(longint z, longint lim);
      longint v;
      v = shr_floor(z + 8192, 14);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic attitude_type predict_attitude(longint ax, longint ay, longint az,
                                                     longint mx, longint my);
      attitude_type a;
      longint       r, head;
      a.roll = 15'(q20_to_q6_clamped(atan2_q20(ay * 256, az * 256), 11520));
      r = floor_sqrt(longint'(ay * ay + az * az) << 16);
      a.pitch = 14'(q20_to_q6_clamped(atan2_q20(-ax * 256, r), 5760));
      if (my == 0) head = (mx < 0) ? 11520 : 0;
      else head = q20_to_q6_clamped(atan2_q20(mx * 256, my * 256), 11520);
      head -= longint'(decl_model);
      if (head > 11520) head -= 23040;
      else if (head < -11520) head += 23040;
      if (head > 11520) head = 11520;
      if (head < -11520) head = -11520;
      a.heading = 15'(head);
      return a;
   endfunction

   // result checker
   always @(posedge clock) begin
      attitude_type e;
      if (!reset && rsp_valid) begin
         if (pending_attitudes.size() == 0) begin
            $error("unexpected result");
            fail_count++;
         end else begin
            e = pending_attitudes.pop_front();
            if (rsp_roll_angle !== e.roll) begin
               $error("roll_angle expected %0d got %0d", e.roll, rsp_roll_angle);
               fail_count++;
            end
            if (rsp_pitch_angle !== e.pitch) begin
               $error("pitch_angle expected %0d got %0d", e.pitch, rsp_pitch_angle);
               fail_count++;
            end
            if (rsp_heading_angle !== e.heading) begin
               $error("heading_angle expected %0d got %0d", e.heading,
                      rsp_heading_angle);
               fail_count++;
            end
         end
      end
   end

   // send one sample; gap idle cycles beforehand, start stays high after
   // the item so back-to-back items need no gap
   task automatic send_sample(logic signed [15:0] ax, ay, az, mx, my, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_mag_x <= mx;
      req_mag_y <= my;
      do @(posedge clock); while (busy);
      pending_attitudes.push_back(predict_attitude(ax, ay, az, mx, my));
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_attitudes.size() != 0) @(negedge clock);
   endtask

   task automatic set_declination(logic signed [14:0] d);
      drain();
      repeat (4) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= d;
      @(negedge clock);
      csr_write <= 1'b0;
      decl_model = d;
   endtask

   function automatic logic signed [15:0] rand16();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 6)) - 3);
         3: return 16'(int'($urandom_range(0, 512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // extremes, zero operands, mag_y zero, wrap cases
   task automatic test_directed();
      logic signed [15:0] ext[5];
      ext = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_sample(16'sh7fff, 0, 0, -5, 0, 1);
      send_sample(16'sh8000, 0, -1, 5, 0, 0);
      send_sample(0, 1, -100, 0, -200, 0);
      send_sample(0, -1, -100, 0, 0, 0);
      for (int i = 0; i < 5; i++)
         send_sample(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], ext[(i + 3) % 5],
                     ext[(i + 4) % 5], 0);
   endtask

   task automatic test_declination_extremes();
      logic signed [14:0] d[3];
      d = '{15'sd11520, -15'sd11520, 15'sd100};
      foreach (d[k]) begin
         set_declination(d[k]);
         send_sample(0, 0, 0, -3, 0, 0);
         send_sample(0, 0, 0, 3, 0, 0);
         send_sample(10, 20, 30, -40, -50, 0);
         send_sample(10, 20, 30, 40, 50, 2);
      end
   endtask

   task automatic test_random(int n, bit idle);
      int gap;
      for (int i = 0; i < n; i++) begin
         gap = (idle && $urandom_range(0, 3) != 0) ? $urandom_range(0, 14) : 0;
         send_sample(rand16(), rand16(), rand16(), rand16(), rand16(), gap);
      end
   endtask

   initial begin
      int wait_left;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_declination_extremes();
      set_declination(0);
      test_random(300, 1'b0);
      set_declination(15'(int'($urandom_range(0, 23040)) - 11520));
      test_random(400, 1'b1);
      set_declination(15'(int'($urandom_range(0, 23040)) - 11520));
      test_random(500, 1'b1);
      drain();
      wait_left = 2 * LATENCY;
      while (wait_left > 0) begin
         @(negedge clock);
         wait_left--;
      end
      if (fail_count == 0 && pending_attitudes.size() == 0)
         $display("attitude_roll_pitch_heading regression: pass");
      else
         $display("attitude_roll_pitch_heading regression: fail");
      $finish;
   end
endmodule

// ===== attitude_roll_pitch_heading.f =====
rtl/arph_pkg.sv
rtl/arph_front.sv
rtl/arph_queue.sv
rtl/arph_back.sv
rtl/attitude_roll_pitch_heading.sv
tb/tb_attitude_roll_pitch_heading.sv
